FILE: sv/lvm_pkg.sv
`default_nettype none
package lvm_pkg;

  localparam int CHANNELS   = 2;
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = SAMPLE_W - 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = 44;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int GAIN_W     = 16;
  localparam int WIN_W      = 14;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 2 * SAMPLE_W;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USED_W = 4 * MAG_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_DECAY_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RMS_WINDOW      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 2'd2;

  localparam logic [GAIN_W-1:0] DECAY_GAIN_RST      = 16'd62259;
  localparam logic [WIN_W-1:0]  RMS_WINDOW_RST      = 14'd2048;
  localparam logic [ACT_W-1:0]  ACTIVE_CHANNELS_RST = 2'd2;

  typedef struct packed {
    logic [CHANNELS-1:0]            active;
    logic                           block_end;
    logic [CHANNELS-1:0][MAG_W-1:0] mag;
  } frame_t;

  typedef struct packed {
    logic                           updated;
    logic [CHANNELS-1:0][MAG_W-1:0] rms;
    logic [CHANNELS-1:0][MAG_W-1:0] peak;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/audio_peak_rms_level_meter_core.sv
// Two-channel audio level meter: held peak with per-block decay, windowed RMS.
// Input stream: one frame per transfer, both Q1.15 samples in in_tdata, block
// end on in_tlast. Output stream: one result per input frame, held peaks and
// RMS levels in out_tdata, the RMS refresh flag in out_tuser.
// Configuration: write cfg_wdata to register cfg_addr on any edge with cfg_we
// (0 decay gain, 1 RMS window, 2 active channels); write only while idle.
// Per frame the back end captures it from the queue, squares, accumulates, and on
// a block end updates the held peaks; when the RMS levels then refresh, the shared
// divide/square-root unit runs a divide and a square root per active channel,
// before the result goes to the output register. The back-end sequencer takes no
// new frame until it has handed its result on; a four-entry queue between front
// and back absorbs bursts.
// Reset (rst_n low, synchronous) clears peaks, sums, count and RMS levels,
// restores the register defaults and empties the pipeline.
// When out_tready is low the result holds in the output register; the back
// end stops, the queue fills, and then in_tready drops.
`default_nettype none
module audio_peak_rms_level_meter_core #(
  parameter int MAX_WINDOW = 8192
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [lvm_pkg::IN_DATA_W-1:0]     in_tdata,   // sample_ch0, sample_ch1
  input  wire                              in_tlast,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [lvm_pkg::OUT_DATA_W-1:0]   out_tdata,  // peak_ch0, peak_ch1, rms_ch0, rms_ch1
  output logic                             out_tuser,  // rms_updated
  input  wire                              cfg_we,
  input  wire [lvm_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire [lvm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import lvm_pkg::*;

  logic [GAIN_W-1:0] decay_gain_r;
  logic [WIN_W-1:0]  rms_window_r;
  logic [ACT_W-1:0]  active_channels_r;

  logic    push_valid;
  logic    push_ready;
  frame_t  push_frame;
  logic    pop_valid;
  logic    pop_ready;
  frame_t  pop_frame;
  result_t res_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_gain_r      <= DECAY_GAIN_RST;
      rms_window_r      <= RMS_WINDOW_RST;
      active_channels_r <= ACTIVE_CHANNELS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DECAY_GAIN:      decay_gain_r      <= cfg_wdata[GAIN_W-1:0];
        REG_RMS_WINDOW:      rms_window_r      <= cfg_wdata[WIN_W-1:0];
        REG_ACTIVE_CHANNELS: active_channels_r <= cfg_wdata[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  lvm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .sample_ch0      (in_tdata[SAMPLE_W-1:0]),
    .sample_ch1      (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .block_end       (in_tlast),
    .active_channels (active_channels_r),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_frame      (push_frame)
  );

  lvm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_frame  (pop_frame)
  );

  lvm_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_frame  (pop_frame),
    .decay_gain (decay_gain_r),
    .rms_window (rms_window_r),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_data   (res_data)
  );

  assign out_tdata = {(OUT_DATA_W - OUT_USED_W)'(0), res_data.rms, res_data.peak};
  assign out_tuser = res_data.updated;

endmodule
`default_nettype wire

FILE: sv/lvm_front.sv
`default_nettype none
module lvm_front (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire [lvm_pkg::SAMPLE_W-1:0] sample_ch0,
  input  wire [lvm_pkg::SAMPLE_W-1:0] sample_ch1,
  input  wire                         block_end,
  input  wire [lvm_pkg::ACT_W-1:0]    active_channels,
  output logic                        push_valid,
  input  wire                         push_ready,
  output lvm_pkg::frame_t             push_frame
);
  import lvm_pkg::*;

  logic   vld_r;
  frame_t frame_r;
  frame_t frame_nxt;

  function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] neg;
    neg = ~s + SAMPLE_W'(1);
    if (!s[SAMPLE_W-1]) begin
      return s[MAG_W-1:0];
    end else if (neg[SAMPLE_W-1]) begin
      return MAG_MAX;
    end else begin
      return neg[MAG_W-1:0];
    end
  endfunction

  // channel 0 always metered; channel 1 when two or more are requested
  always_comb begin
    frame_nxt.active    = {active_channels[1], 1'b1};
    frame_nxt.block_end = block_end;
    frame_nxt.mag[0]    = magnitude(sample_ch0);
    frame_nxt.mag[1]    = active_channels[1] ? magnitude(sample_ch1) : '0;
  end

  assign in_ready   = !vld_r || push_ready;
  assign push_valid = vld_r;
  assign push_frame = frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_r <= frame_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/lvm_queue.sv
`default_nettype none
module lvm_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push_valid,
  output logic            push_ready,
  input  lvm_pkg::frame_t push_frame,
  output logic            pop_valid,
  input  wire             pop_ready,
  output lvm_pkg::frame_t pop_frame
);
  import lvm_pkg::*;

  frame_t                 mem_r [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr_ptr_r;
  logic [QUEUE_IDX_W-1:0] rd_ptr_r;
  logic [QUEUE_IDX_W:0]   cnt_r;
  logic                   push;
  logic                   pop;

  assign push_ready = cnt_r != (QUEUE_IDX_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_frame  = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_IDX_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_IDX_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QUEUE_IDX_W + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QUEUE_IDX_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

endmodule
`default_nettype wire

FILE: sv/lvm_divsqrt.sv
`default_nettype none
module lvm_divsqrt #(
  parameter int CNT_W = 14
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [lvm_pkg::SUM_W-1:0]   dividend,
  input  wire [CNT_W-1:0]            divisor,
  output logic                       done,
  output logic [lvm_pkg::MAG_W-1:0]  result
);
  import lvm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_DIV  = 3'b010,
    U_SQRT = 3'b100
  } ustate_t;

  ustate_t             state_r;
  logic [STEP_W-1:0]   step_r;
  logic [CNT_W-1:0]    div_r;
  logic [CNT_W-1:0]    rem_r;
  logic [SUM_W-1:0]    quo_r;
  logic [ROOT_W+1:0]   r_r;
  logic [ROOT_W-1:0]   q_r;
  logic                done_r;
  logic [MAG_W-1:0]    result_r;

  logic [CNT_W:0]      d_trial;
  logic                d_ge;
  logic [CNT_W:0]      d_diff;
  logic [ROOT_W+3:0]   s_trial;
  logic [ROOT_W+3:0]   s_test;
  logic                s_ge;
  logic [ROOT_W+3:0]   s_diff;
  logic [ROOT_W+1:0]   r_nxt;
  logic [ROOT_W-1:0]   q_nxt;

  always_comb begin
    d_trial = {rem_r, quo_r[SUM_W-1]};
    d_ge    = d_trial >= {1'b0, div_r};
    d_diff  = d_trial - {1'b0, div_r};
    s_trial = {r_r, quo_r[SUM_W-1:SUM_W-2]};
    s_test  = (ROOT_W + 4)'({q_r, 2'b01});
    s_ge    = s_trial >= s_test;
    s_diff  = s_trial - s_test;
    r_nxt   = s_ge ? s_diff[ROOT_W+1:0] : s_trial[ROOT_W+1:0];
    q_nxt   = {q_r[ROOT_W-2:0], s_ge};
  end

  assign done   = done_r;
  assign result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        U_IDLE: begin
          if (start) begin
            state_r <= U_DIV;
          end
        end
        U_DIV: begin
          if (step_r == STEP_W'(SUM_W - 1)) begin
            state_r <= U_SQRT;
          end
        end
        U_SQRT: begin
          if (step_r == STEP_W'(ROOT_W - 1)) begin
            state_r <= U_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      U_IDLE: begin
        step_r <= '0;
        div_r  <= divisor;
        rem_r  <= '0;
        quo_r  <= dividend;
      end
      U_DIV: begin
        rem_r <= d_ge ? d_diff[CNT_W-1:0] : d_trial[CNT_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], d_ge};
        r_r   <= '0;
        q_r   <= '0;
        step_r <= (step_r == STEP_W'(SUM_W - 1)) ? '0 : step_r + STEP_W'(1);
      end
      U_SQRT: begin
        r_r    <= r_nxt;
        q_r    <= q_nxt;
        quo_r  <= {quo_r[SUM_W-3:0], 2'b00};
        step_r <= step_r + STEP_W'(1);
        if (q_nxt > ROOT_W'(MAG_MAX)) begin
          result_r <= MAG_MAX;
        end else begin
          result_r <= q_nxt[MAG_W-1:0];
        end
      end
      default: step_r <= '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/lvm_back.sv
`default_nettype none
module lvm_back #(
  parameter int MAX_WINDOW = 8192
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        pop_valid,
  output logic                       pop_ready,
  input  lvm_pkg::frame_t            pop_frame,
  input  wire [lvm_pkg::GAIN_W-1:0]  decay_gain,
  input  wire [lvm_pkg::WIN_W-1:0]   rms_window,
  output logic                       res_valid,
  input  wire                        res_ready,
  output lvm_pkg::result_t           res_data
);
  import lvm_pkg::*;

  localparam int CNT_W = $clog2(2 * MAX_WINDOW);
  localparam int CW    = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int PRD_W = MAG_W + GAIN_W;
  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(2 * MAX_WINDOW - 1);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_SQ        = 7'b0000010,
    S_ACC       = 7'b0000100,
    S_PEAK      = 7'b0001000,
    S_RMS_START = 7'b0010000,
    S_RMS_WAIT  = 7'b0100000,
    S_OUT       = 7'b1000000
  } state_t;

  state_t                          state_r;
  state_t                          state_nxt;
  frame_t                          cur_r;
  logic [CHANNELS-1:0][SQ_W-1:0]   sq_r;
  logic [CHANNELS-1:0][SUM_W-1:0]  sum_r;
  logic [CHANNELS-1:0][MAG_W-1:0]  blk_r;
  logic [CHANNELS-1:0][MAG_W-1:0]  held_r;
  logic [CHANNELS-1:0][MAG_W-1:0]  rms_r;
  logic [CNT_W-1:0]                cnt_r;
  logic                            ch_r;
  logic                            upd_r;
  logic                            res_valid_r;
  result_t                         res_r;

  logic [CHANNELS-1:0][SUM_W:0]    sum_ext;
  logic [CHANNELS-1:0][PRD_W-1:0]  prod;
  logic [CW-1:0]                   win;
  logic                            refresh;
  logic                            out_free;
  logic                            unit_start;
  logic                            unit_done;
  logic [MAG_W-1:0]                unit_result;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      sum_ext[c] = {1'b0, sum_r[c]} + (SUM_W + 1)'(sq_r[c]);
      prod[c]    = PRD_W'(held_r[c]) * PRD_W'(decay_gain);
    end
    if (rms_window == '0) begin
      win = CW'(1);
    end else if (CW'(rms_window) > CW'(MAX_WINDOW)) begin
      win = CW'(MAX_WINDOW);
    end else begin
      win = CW'(rms_window);
    end
    refresh = CW'(cnt_r) >= win;
  end

  assign out_free   = !res_valid_r || res_ready;
  assign pop_ready  = state_r == S_IDLE;
  assign unit_start = state_r == S_RMS_START;
  assign res_valid  = res_valid_r;
  assign res_data   = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (pop_valid) state_nxt = S_SQ;
      S_SQ:        state_nxt = S_ACC;
      S_ACC:       state_nxt = cur_r.block_end ? S_PEAK : S_OUT;
      S_PEAK:      state_nxt = refresh ? S_RMS_START : S_OUT;
      S_RMS_START: state_nxt = S_RMS_WAIT;
      S_RMS_WAIT: begin
        if (unit_done) begin
          state_nxt = (!ch_r && cur_r.active[1]) ? S_RMS_START : S_OUT;
        end
      end
      S_OUT:       if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  lvm_divsqrt #(
    .CNT_W (CNT_W)
  ) u_divsqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (unit_start),
    .dividend (sum_r[ch_r]),
    .divisor  (cnt_r),
    .done     (unit_done),
    .result   (unit_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      sum_r       <= '0;
      blk_r       <= '0;
      held_r      <= '0;
      rms_r       <= '0;
      cnt_r       <= '0;
      ch_r        <= 1'b0;
      upd_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_ACC: begin
          upd_r <= 1'b0;
          ch_r  <= 1'b0;
          for (int c = 0; c < CHANNELS; c++) begin
            if (cur_r.mag[c] > blk_r[c]) begin
              blk_r[c] <= cur_r.mag[c];
            end
            sum_r[c] <= sum_ext[c][SUM_W] ? SUM_MAX : sum_ext[c][SUM_W-1:0];
          end
          if (cnt_r != COUNT_MAX) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_PEAK: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (cur_r.active[c]) begin
              held_r[c] <= (blk_r[c] > held_r[c]) ? blk_r[c] : prod[c][PRD_W-1:GAIN_W];
            end
          end
          blk_r <= '0;
        end
        S_RMS_WAIT: begin
          if (unit_done) begin
            rms_r[ch_r] <= unit_result;
            if (!ch_r && cur_r.active[1]) begin
              ch_r <= 1'b1;
            end else begin
              sum_r <= '0;
              cnt_r <= '0;
              upd_r <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && pop_valid) begin
      cur_r <= pop_frame;
    end
    if (state_r == S_SQ) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sq_r[c] <= SQ_W'(cur_r.mag[c]) * SQ_W'(cur_r.mag[c]);
      end
    end
    if (state_r == S_OUT && out_free) begin
      res_r.updated <= upd_r;
      res_r.rms     <= rms_r;
      res_r.peak    <= held_r;
    end
  end

endmodule
`default_nettype wire

FILE: sv/lvm_checker.sv
`default_nettype none
module lvm_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            out_tvalid,
  input wire                            out_tready,
  input wire [lvm_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire                            out_tuser
);

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a result must pass the front register, the queue and the back-end states before it shows after reset
  a_min_latency: assert property (@(posedge clk) !rst_n |-> ##2 !out_tvalid)
    else $error("result appeared too soon after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind audio_peak_rms_level_meter_core lvm_checker u_lvm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
